FILE: hw/rtl/ssu_pkg.sv
package ssu_pkg;

  // List geometry and value width.
  localparam int LIST_CAPACITY = 32;
  localparam int VALUE_BITS    = 32;

  // Derived widths: a list length runs 0..capacity, a union length 0..2*capacity.
  localparam int CNT_W  = $clog2(LIST_CAPACITY + 1);
  localparam int ADDR_W = $clog2(LIST_CAPACITY);
  localparam int TOT_W  = $clog2(2 * LIST_CAPACITY + 1);

  // Fixed port field widths.
  localparam int KIND_BITS    = 2;
  localparam int STATUS_BITS  = 3;
  localparam int ELEMENT_BITS = 32;
  localparam int COUNT_BITS   = 7;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_INS_A = 2'd0,
    KIND_INS_B = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_MERGE = 2'd3
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_INSERTED    = 3'd0,
    ST_DUPLICATE   = 3'd1,
    ST_FULL        = 3'd2,
    ST_CLEARED     = 3'd3,
    ST_MERGED      = 3'd4,
    ST_MERGE_EMPTY = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_PLACE,
    S_MERGE,
    S_EMIT
  } state_t;

endpackage

FILE: hw/rtl/sorted_set_insert_and_union.sv
// Two sorted sets of signed values, each kept ascending without duplicates in a
// RAM of LIST_CAPACITY entries with one read and one write port. One word is
// taken at a time. in_ready is low while a word is being worked on. A finished
// result waits in the output register without holding up the next input word.
// On an insert, one comparator scans forward to the insert position at one
// entry per cycle, then the tail is moved up one entry per cycle through the
// RAM port. On a merge, the same comparator walks both lists once to count
// the union and once more to emit it, one element per cycle while the output
// side keeps up. Both RAMs have registered read data and need no clearing
// after reset.
module sorted_set_insert_and_union (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ssu_pkg::KIND_BITS-1:0]       in_kind,
  input  logic signed [ssu_pkg::ELEMENT_BITS-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ssu_pkg::STATUS_BITS-1:0]     out_status,
  output logic signed [ssu_pkg::ELEMENT_BITS-1:0] out_element,
  output logic [ssu_pkg::COUNT_BITS-1:0]      out_count,
  output logic                                out_last
);

  localparam int CAP = ssu_pkg::LIST_CAPACITY;
  localparam int VW  = ssu_pkg::VALUE_BITS;
  localparam int CW  = ssu_pkg::CNT_W;
  localparam int AW  = ssu_pkg::ADDR_W;
  localparam int TW  = ssu_pkg::TOT_W;

  // List storage.
  logic [VW-1:0] mem_a [CAP];
  logic [VW-1:0] mem_b [CAP];
  logic [VW-1:0] rd_a_r;
  logic [VW-1:0] rd_b_r;

  ssu_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt;
  logic [CW-1:0] cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] ia_r, ia_nxt;
  logic [CW-1:0] ib_r, ib_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [TW-1:0] k_r, k_nxt;
  logic [TW-1:0] tot_r, tot_nxt;
  logic          pass_r, pass_nxt;
  logic          sel_r, sel_nxt;
  logic [VW-1:0] val_r, val_nxt;

  logic [ssu_pkg::STATUS_BITS-1:0] res_status_r, res_status_nxt;
  logic [VW-1:0]                   res_element_r, res_element_nxt;
  logic [ssu_pkg::COUNT_BITS-1:0]  res_count_r, res_count_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [ssu_pkg::STATUS_BITS-1:0]  out_status_r, out_status_nxt;
  logic [ssu_pkg::ELEMENT_BITS-1:0] out_element_r, out_element_nxt;
  logic [ssu_pkg::COUNT_BITS-1:0]   out_count_r, out_count_nxt;
  logic                             out_last_r, out_last_nxt;

  logic          in_fire;
  logic          out_free;
  logic          load_out;
  logic [CW-1:0] n_sel;
  logic [VW-1:0] rd_sel;
  logic [VW-1:0] op_x;
  logic [VW-1:0] op_y;
  logic          cmp_lt;
  logic          cmp_eq;
  logic          a_ok;
  logic          b_ok;
  logic          pick_a;
  logic [VW-1:0] pick;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;

  assign in_ready = (state_r == ssu_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign n_sel  = sel_r ? cnt_b_r : cnt_a_r;
  assign rd_sel = sel_r ? rd_b_r : rd_a_r;

  // Shared comparator: list entry against the new value while inserting,
  // head of A against head of B while merging.
  assign op_x   = rd_sel;
  assign op_y   = (state_r == ssu_pkg::S_MERGE) ? rd_b_r : val_r;
  assign cmp_lt = $signed(op_x) < $signed(op_y);
  assign cmp_eq = (op_x == op_y);

  // Merge pick: the smaller head, A on a tie (B then skips its copy).
  assign a_ok   = (ia_r < cnt_a_r);
  assign b_ok   = (ib_r < cnt_b_r);
  assign pick_a = !b_ok || (a_ok && (cmp_lt || cmp_eq));
  assign pick   = pick_a ? rd_a_r : rd_b_r;

  // Sequencer.
  always_comb begin
    state_nxt       = state_r;
    cnt_a_nxt       = cnt_a_r;
    cnt_b_nxt       = cnt_b_r;
    ia_nxt          = ia_r;
    ib_nxt          = ib_r;
    pos_nxt         = pos_r;
    k_nxt           = k_r;
    tot_nxt         = tot_r;
    pass_nxt        = pass_r;
    sel_nxt         = sel_r;
    val_nxt         = val_r;
    res_status_nxt  = res_status_r;
    res_element_nxt = res_element_r;
    res_count_nxt   = res_count_r;
    load_out        = 1'b0;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_count_nxt   = out_count_r;
    out_last_nxt    = out_last_r;
    wr_en           = 1'b0;
    wr_addr         = pos_r;
    wr_data         = val_r;

    unique case (state_r)
      ssu_pkg::S_IDLE: begin
        if (in_fire) begin
          ia_nxt  = '0;
          ib_nxt  = '0;
          k_nxt   = '0;
          pass_nxt = 1'b0;
          val_nxt = VW'($unsigned(in_value));
          unique case (ssu_pkg::kind_t'(in_kind))
            ssu_pkg::KIND_INS_A, ssu_pkg::KIND_INS_B: begin
              sel_nxt   = (ssu_pkg::kind_t'(in_kind) == ssu_pkg::KIND_INS_B);
              state_nxt = ssu_pkg::S_SEARCH;
            end
            ssu_pkg::KIND_CLEAR: begin
              cnt_a_nxt       = '0;
              cnt_b_nxt       = '0;
              res_status_nxt  = ssu_pkg::ST_CLEARED;
              res_element_nxt = '0;
              res_count_nxt   = '0;
              state_nxt       = ssu_pkg::S_EMIT;
            end
            ssu_pkg::KIND_MERGE: begin
              sel_nxt = 1'b0;
              if (cnt_a_r == '0 && cnt_b_r == '0) begin
                res_status_nxt  = ssu_pkg::ST_MERGE_EMPTY;
                res_element_nxt = '0;
                res_count_nxt   = '0;
                state_nxt       = ssu_pkg::S_EMIT;
              end else begin
                state_nxt = ssu_pkg::S_MERGE;
              end
            end
            default: state_nxt = ssu_pkg::S_IDLE;
          endcase
        end
      end

      // Forward scan: stop at the first entry not below the value.
      ssu_pkg::S_SEARCH: begin
        if (ia_r < n_sel && cmp_lt) begin
          ia_nxt = CW'(ia_r + 1'b1);
          ib_nxt = CW'(ia_r + 1'b1);
        end else begin
          res_element_nxt = val_r;
          res_count_nxt   = ssu_pkg::COUNT_BITS'(n_sel);
          if (ia_r < n_sel && cmp_eq) begin
            res_status_nxt = ssu_pkg::ST_DUPLICATE;
            state_nxt      = ssu_pkg::S_EMIT;
          end else if (n_sel == CW'(CAP)) begin
            res_status_nxt = ssu_pkg::ST_FULL;
            state_nxt      = ssu_pkg::S_EMIT;
          end else begin
            pos_nxt = ia_r[AW-1:0];
            if (ia_r == n_sel) begin
              state_nxt = ssu_pkg::S_PLACE;
            end else begin
              ia_nxt    = CW'(n_sel - 1'b1);
              ib_nxt    = CW'(n_sel - 1'b1);
              state_nxt = ssu_pkg::S_SHIFT;
            end
          end
        end
      end

      // Move the tail up by one entry, from the top down to the insert position.
      ssu_pkg::S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = AW'(ia_r + 1'b1);
        wr_data = rd_sel;
        if (ia_r[AW-1:0] == pos_r) begin
          state_nxt = ssu_pkg::S_PLACE;
        end else begin
          ia_nxt = CW'(ia_r - 1'b1);
          ib_nxt = CW'(ia_r - 1'b1);
        end
      end

      ssu_pkg::S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = val_r;
        if (sel_r) begin
          cnt_b_nxt = CW'(cnt_b_r + 1'b1);
        end else begin
          cnt_a_nxt = CW'(cnt_a_r + 1'b1);
        end
        res_status_nxt  = ssu_pkg::ST_INSERTED;
        res_element_nxt = val_r;
        res_count_nxt   = ssu_pkg::COUNT_BITS'(CW'(n_sel + 1'b1));
        state_nxt       = ssu_pkg::S_EMIT;
      end

      // First pass counts the union, second pass emits it.
      ssu_pkg::S_MERGE: begin
        if (!a_ok && !b_ok) begin
          tot_nxt  = k_r;
          pass_nxt = 1'b1;
          ia_nxt   = '0;
          ib_nxt   = '0;
          k_nxt    = '0;
        end else if (!pass_r || out_free) begin
          k_nxt = TW'(k_r + 1'b1);
          if (pick_a) begin
            ia_nxt = CW'(ia_r + 1'b1);
          end
          if (!pick_a || (a_ok && b_ok && cmp_eq)) begin
            ib_nxt = CW'(ib_r + 1'b1);
          end
          if (pass_r) begin
            load_out        = 1'b1;
            out_status_nxt  = ssu_pkg::ST_MERGED;
            out_element_nxt = ssu_pkg::ELEMENT_BITS'(pick);
            out_count_nxt   = ssu_pkg::COUNT_BITS'(tot_r);
            out_last_nxt    = (TW'(k_r + 1'b1) == tot_r);
            if (TW'(k_r + 1'b1) == tot_r) begin
              state_nxt = ssu_pkg::S_IDLE;
            end
          end
        end
      end

      ssu_pkg::S_EMIT: begin
        if (out_free) begin
          load_out        = 1'b1;
          out_status_nxt  = res_status_r;
          out_element_nxt = ssu_pkg::ELEMENT_BITS'(res_element_r);
          out_count_nxt   = res_count_r;
          out_last_nxt    = 1'b1;
          state_nxt       = ssu_pkg::S_IDLE;
        end
      end

      default: state_nxt = ssu_pkg::S_IDLE;
    endcase

    out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssu_pkg::S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers and output word.
  always_ff @(posedge clk) begin
    ia_r          <= ia_nxt;
    ib_r          <= ib_nxt;
    pos_r         <= pos_nxt;
    k_r           <= k_nxt;
    tot_r         <= tot_nxt;
    pass_r        <= pass_nxt;
    sel_r         <= sel_nxt;
    val_r         <= val_nxt;
    res_status_r  <= res_status_nxt;
    res_element_r <= res_element_nxt;
    res_count_r   <= res_count_nxt;
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_count_r   <= out_count_nxt;
    out_last_r    <= out_last_nxt;
  end

  // RAMs: the read address follows the next index, so read data always
  // matches the current index.
  always_ff @(posedge clk) begin
    if (wr_en && !sel_r) begin
      mem_a[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_a[ia_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_en && sel_r) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_b_r <= mem_b[ib_nxt[AW-1:0]];
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = $signed(out_element_r);
  assign out_count   = out_count_r;
  assign out_last    = out_last_r;

  // A new word never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free)
    else $error("output word overwritten before it was taken");

  // An insert is only placed into a list that still has room.
  a_place_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ssu_pkg::S_PLACE) |-> (n_sel < CW'(CAP)))
    else $error("insert placed into a full list");

  // The emit pass never runs past the union size counted in the first pass.
  a_merge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ssu_pkg::S_MERGE && pass_r && load_out) |-> (k_r < tot_r))
    else $error("merge emitted more words than the union holds");

  // A clear leaves both lists empty.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && ssu_pkg::kind_t'(in_kind) == ssu_pkg::KIND_CLEAR)
      |=> (cnt_a_r == '0 && cnt_b_r == '0))
    else $error("clear did not empty the lists");

endmodule
